>>> rtl/core/hwf_pkg.sv
// ----------------------------------------------------------------------------
// hwf_pkg
// Shared widths, codes and types of the Holt-Winters forecaster.
// ----------------------------------------------------------------------------
`default_nettype none

package hwf_pkg;

	localparam int SEASON_LEN = 12;
	localparam int SLOT_W     = $clog2(SEASON_LEN);
	localparam int SEEN_W     = $clog2(SEASON_LEN + 2);
	localparam int MAX_STEPS  = 12;

	localparam int GAIN_W     = 17;
	localparam int SALE_W     = 16;
	localparam int HOR_W      = 4;
	localparam int OUT_W      = 25;
	localparam int LEVEL_W    = 40;
	localparam int DIFF_W     = LEVEL_W + 1;
	localparam int FT_W       = LEVEL_W + HOR_W;
	localparam int FACTOR_W   = 24;
	localparam int FRAC_W     = 16;
	localparam int LO_W       = 24;
	localparam int OUT_SH     = 32;

	localparam int OPND_W     = 25;
	localparam int PROD_W     = 2 * OPND_W;
	localparam int ACC_W      = 66;

	localparam int QUO_W      = FACTOR_W;
	localparam int DIVR_W     = LEVEL_W;
	localparam int RATIO_SH   = 32;
	localparam int HEAD_W     = SALE_W + RATIO_SH - QUO_W;

	localparam int CFG_IDX_W  = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_GAIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TREND_GAIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEASON_GAIN = 2'd2;

	localparam logic OP_SAMPLE   = 1'b0;
	localparam logic OP_FORECAST = 1'b1;

	localparam logic [1:0] SH_0  = 2'd0;
	localparam logic [1:0] SH_16 = 2'd1;
	localparam logic [1:0] SH_24 = 2'd2;

	typedef struct packed {
		logic       issue;
		logic       clear;
		logic [1:0] shift;
	} mac_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/hwf_mac.sv
// ----------------------------------------------------------------------------
// hwf_mac
// Shared signed multiplier with a registered product and a shifting
// accumulator. The result is readable once it has passed the product register and then the accumulator register.
// ----------------------------------------------------------------------------
`default_nettype none

module hwf_mac import hwf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mac_cmd_t                 cmd,
	input  logic signed [OPND_W-1:0] opnd_a,
	input  logic signed [OPND_W-1:0] opnd_b,
	output logic signed [ACC_W-1:0]  acc
);

	mac_cmd_t                 cmd_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  term;
	logic signed [ACC_W-1:0]  base;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
		end else begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			prod_s1 <= opnd_a * opnd_b;
		end
	end

	assign prod_ext = ACC_W'(prod_s1);

	always_comb begin
		unique case (cmd_s1.shift)
			SH_16:   term = prod_ext <<< FRAC_W;
			SH_24:   term = prod_ext <<< LO_W;
			default: term = prod_ext;
		endcase
	end

	assign base = cmd_s1.clear ? ACC_W'(0) : acc_q;

	always_ff @(posedge clk) begin
		if (cmd_s1.issue) begin
			acc_q <= base + term;
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

>>> rtl/core/hwf_div.sv
// ----------------------------------------------------------------------------
// hwf_div
// Radix-2 restoring divider for the seasonal ratio sale * 2^32 / level,
// saturated to the factor width. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hwf_div import hwf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SALE_W-1:0] sale,
	input  logic [DIVR_W-1:0] divisor,
	output logic              done,
	output logic [QUO_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] dvs_q;
	logic [QUO_W-1:0]  quo_q;
	logic [HEAD_W-1:0] head;
	logic [DIVR_W-1:0] head_ext;
	logic              sat;
	logic [DIVR_W:0]   rem2;
	logic [DIVR_W:0]   diff;

	// top part of the dividend; quotient overflows when it reaches the divisor
	assign head     = {sale, (HEAD_W - SALE_W)'(0)};
	assign head_ext = DIVR_W'(head);
	assign sat      = (head_ext >= divisor);
	assign rem2     = {rem_q, 1'b0};
	assign diff     = rem2 - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (sat) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(QUO_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= head_ext;
			quo_q <= sat ? '1 : '0;
		end else if (busy_q) begin
			if (!diff[DIVR_W]) begin
				rem_q <= diff[DIVR_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= rem2[DIVR_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> rtl/core/holt_winters_forecaster.sv
// ----------------------------------------------------------------------------
// holt_winters_forecaster
// Triple exponential smoothing with multiplicative season over monthly sales.
// ----------------------------------------------------------------------------
// Sample beat: level and trend updates, then, when the seasonal factor is
//   updated, the serial divider (which finishes at once when the ratio
//   saturates) and the factor update; the first sample only seeds the level.
//   Forecast beat: one month at a time, each through the one shared
//   multiplier. One beat in flight; in_ready only when idle.
// Reset: asynchronous, clears level, trend and counters, sets all seasonal
//   factors to 1.0 and the gains to 0.5, 0.1 and 0.9.
// ----------------------------------------------------------------------------
`default_nettype none

module holt_winters_forecaster import hwf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write_en,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [GAIN_W-1:0]       cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    operation,
	input  logic [SALE_W-1:0]       sale_count,
	input  logic [HOR_W-1:0]        horizon,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] forecast,
	output logic [HOR_W-1:0]        step_ahead,
	output logic                    last,
	output logic                    level_fault
);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_L1   = 5'd1;
	localparam logic [4:0] ST_L2   = 5'd2;
	localparam logic [4:0] ST_L3   = 5'd3;
	localparam logic [4:0] ST_L4   = 5'd4;
	localparam logic [4:0] ST_L5   = 5'd5;
	localparam logic [4:0] ST_T0   = 5'd6;
	localparam logic [4:0] ST_T1   = 5'd7;
	localparam logic [4:0] ST_T2   = 5'd8;
	localparam logic [4:0] ST_T3   = 5'd9;
	localparam logic [4:0] ST_T4   = 5'd10;
	localparam logic [4:0] ST_T5   = 5'd11;
	localparam logic [4:0] ST_T6   = 5'd12;
	localparam logic [4:0] ST_D0   = 5'd13;
	localparam logic [4:0] ST_D1   = 5'd14;
	localparam logic [4:0] ST_Q1   = 5'd15;
	localparam logic [4:0] ST_Q2   = 5'd16;
	localparam logic [4:0] ST_Q3   = 5'd17;
	localparam logic [4:0] ST_Q4   = 5'd18;
	localparam logic [4:0] ST_ACK  = 5'd19;
	localparam logic [4:0] ST_F0   = 5'd20;
	localparam logic [4:0] ST_F1   = 5'd21;
	localparam logic [4:0] ST_F2   = 5'd22;
	localparam logic [4:0] ST_F3   = 5'd23;
	localparam logic [4:0] ST_F4   = 5'd24;

	localparam logic [GAIN_W-1:0] ONE_Q16  = GAIN_W'(65536);
	localparam logic [GAIN_W-1:0] K_RESET  = GAIN_W'(32768);
	localparam logic [GAIN_W-1:0] B_RESET  = GAIN_W'(6554);
	localparam logic [GAIN_W-1:0] Q_RESET  = GAIN_W'(58982);
	localparam logic [FACTOR_W-1:0] ONE_FACTOR = FACTOR_W'(65536);
	localparam logic [FACTOR_W-1:0] FACTOR_MAX = '1;
	localparam int HALF_Q16 = 32768;
	localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = {1'b0, {(LEVEL_W-1){1'b1}}};
	localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = {1'b1, {(LEVEL_W-1){1'b0}}};
	localparam logic signed [OUT_W-1:0]   OUT_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0]   OUT_MIN   = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0]   TRUNC_BIAS =
		{{(ACC_W-OUT_SH){1'b0}}, {OUT_SH{1'b1}}};

	function automatic logic [GAIN_W-1:0] gain_clamp(input logic [GAIN_W-1:0] d);
		logic [GAIN_W-1:0] r;
		r = (d > ONE_Q16) ? ONE_Q16 : d;
		return r;
	endfunction

	function automatic logic signed [LEVEL_W-1:0] sat_level(
		input logic signed [ACC_W-1:0] v);
		logic signed [LEVEL_W-1:0] r;
		if (v > ACC_W'(LEVEL_MAX)) begin
			r = LEVEL_MAX;
		end else if (v < ACC_W'(LEVEL_MIN)) begin
			r = LEVEL_MIN;
		end else begin
			r = v[LEVEL_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [FACTOR_W-1:0] sat_factor(input logic signed [ACC_W-1:0] v);
		logic [FACTOR_W-1:0] r;
		if (v[ACC_W-1]) begin
			r = '0;
		end else if (v > ACC_W'(FACTOR_MAX)) begin
			r = FACTOR_MAX;
		end else begin
			r = v[FACTOR_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > ACC_W'(OUT_MAX)) begin
			r = OUT_MAX;
		end else if (v < ACC_W'(OUT_MIN)) begin
			r = OUT_MIN;
		end else begin
			r = v[OUT_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		r = (s == SLOT_W'(SEASON_LEN - 1)) ? '0 : s + 1'b1;
		return r;
	endfunction

	// architectural state
	logic [4:0]                state_q;
	logic [GAIN_W-1:0]         k_q;
	logic [GAIN_W-1:0]         b_q;
	logic [GAIN_W-1:0]         q_q;
	logic signed [LEVEL_W-1:0] level_q;
	logic signed [LEVEL_W-1:0] trend_q;
	logic [FACTOR_W-1:0]       season_q [SEASON_LEN];
	logic [SLOT_W-1:0]         ring_q;
	logic [SEEN_W-1:0]         seen_q;
	logic                      out_valid_q;

	// working registers
	logic [SALE_W-1:0]         sale_q;
	logic [SLOT_W-1:0]         slot_q;
	logic                      due_q;
	logic signed [DIFF_W-1:0]  x_q;
	logic signed [LEVEL_W-1:0] nl_q;
	logic                      fault_q;
	logic [HOR_W-1:0]          n_q;
	logic [HOR_W-1:0]          t_q;
	logic signed [FT_W-1:0]    ft_q;
	logic [FACTOR_W-1:0]       fac_q;
	logic signed [OUT_W-1:0]   forecast_q;
	logic [HOR_W-1:0]          step_q;
	logic                      last_q;
	logic                      fault_out_q;

	logic                      in_acc;
	logic                      out_free;
	logic                      nl_pos;
	logic                      t_last;
	logic [HOR_W-1:0]          n_in;
	logic [GAIN_W-1:0]         kc;
	logic [GAIN_W-1:0]         bc;
	logic [GAIN_W-1:0]         qc;
	logic [FACTOR_W-1:0]       season_rd;
	mac_cmd_t                  mac_cmd;
	logic signed [OPND_W-1:0]  opnd_a;
	logic signed [OPND_W-1:0]  opnd_b;
	logic signed [ACC_W-1:0]   acc;
	logic signed [ACC_W-1:0]   acc_rnd;
	logic signed [ACC_W-1:0]   bias;
	logic signed [ACC_W-1:0]   acc_trunc;
	logic                      div_start;
	logic                      div_done;
	logic [QUO_W-1:0]          ratio;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign nl_pos    = !nl_q[LEVEL_W-1] && (nl_q != '0);
	assign t_last    = (t_q == n_q);
	assign kc        = ONE_Q16 - k_q;
	assign bc        = ONE_Q16 - b_q;
	assign qc        = ONE_Q16 - q_q;
	assign season_rd = season_q[slot_q];
	assign div_start = (state_q == ST_D0);

	assign n_in = (horizon == '0) ? HOR_W'(1) :
		((horizon > HOR_W'(MAX_STEPS)) ? HOR_W'(MAX_STEPS) : horizon);

	// nearest, ties up
	assign acc_rnd   = (acc + ACC_W'(HALF_Q16)) >>> FRAC_W;
	// toward zero
	assign bias      = acc[ACC_W-1] ? TRUNC_BIAS : ACC_W'(0);
	assign acc_trunc = (acc + bias) >>> OUT_SH;

	always_comb begin
		mac_cmd = '0;
		opnd_a  = '0;
		opnd_b  = '0;
		unique case (state_q)
			ST_L1: begin
				mac_cmd.issue = 1'b1;
				mac_cmd.clear = 1'b1;
				mac_cmd.shift = SH_16;
				opnd_a        = OPND_W'(sale_q);
				opnd_b        = OPND_W'(k_q);
			end
			ST_L2, ST_T1: begin
				mac_cmd.issue = 1'b1;
				mac_cmd.clear = (state_q == ST_T1);
				mac_cmd.shift = SH_0;
				opnd_a        = OPND_W'(x_q[LO_W-1:0]);
				opnd_b        = (state_q == ST_T1) ? OPND_W'(b_q) : OPND_W'(kc);
			end
			ST_L3, ST_T2: begin
				mac_cmd.issue = 1'b1;
				mac_cmd.shift = SH_24;
				opnd_a        = OPND_W'(signed'(x_q[DIFF_W-1:LO_W]));
				opnd_b        = (state_q == ST_T2) ? OPND_W'(b_q) : OPND_W'(kc);
			end
			ST_T3: begin
				mac_cmd.issue = 1'b1;
				mac_cmd.shift = SH_0;
				opnd_a        = OPND_W'(trend_q[LO_W-1:0]);
				opnd_b        = OPND_W'(bc);
			end
			ST_T4: begin
				mac_cmd.issue = 1'b1;
				mac_cmd.shift = SH_24;
				opnd_a        = OPND_W'(signed'(trend_q[LEVEL_W-1:LO_W]));
				opnd_b        = OPND_W'(bc);
			end
			ST_Q1: begin
				mac_cmd.issue = 1'b1;
				mac_cmd.clear = 1'b1;
				mac_cmd.shift = SH_0;
				opnd_a        = OPND_W'(ratio);
				opnd_b        = OPND_W'(q_q);
			end
			ST_Q2: begin
				mac_cmd.issue = 1'b1;
				mac_cmd.shift = SH_0;
				opnd_a        = OPND_W'(season_rd);
				opnd_b        = OPND_W'(qc);
			end
			ST_F1: begin
				mac_cmd.issue = 1'b1;
				mac_cmd.clear = 1'b1;
				mac_cmd.shift = SH_0;
				opnd_a        = OPND_W'(x_q[LO_W-1:0]);
				opnd_b        = OPND_W'(fac_q);
			end
			ST_F2: begin
				mac_cmd.issue = 1'b1;
				mac_cmd.shift = SH_24;
				opnd_a        = OPND_W'(signed'(x_q[DIFF_W-1:LO_W]));
				opnd_b        = OPND_W'(fac_q);
			end
			default: begin
				mac_cmd = '0;
			end
		endcase
	end

	hwf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.opnd_a (opnd_a),
		.opnd_b (opnd_b),
		.acc    (acc)
	);

	hwf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.sale     (sale_q),
		.divisor  (nl_q[DIVR_W-1:0]),
		.done     (div_done),
		.quotient (ratio)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= K_RESET;
			b_q         <= B_RESET;
			q_q         <= Q_RESET;
			level_q     <= '0;
			trend_q     <= '0;
			ring_q      <= '0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SEASON_LEN; i++) begin
				season_q[i] <= ONE_FACTOR;
			end
		end else begin
			if (cfg_write_en) begin
				unique case (cfg_index)
					CFG_LEVEL_GAIN:  k_q <= gain_clamp(cfg_data);
					CFG_TREND_GAIN:  b_q <= gain_clamp(cfg_data);
					CFG_SEASON_GAIN: q_q <= gain_clamp(cfg_data);
					default: ;
				endcase
			end

			if (((state_q == ST_ACK) || (state_q == ST_F4)) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (operation == OP_FORECAST) begin
							state_q <= ST_F0;
						end else if (seen_q == '0) begin
							// first sample seeds the level
							level_q <= LEVEL_W'(sale_count) << FRAC_W;
							trend_q <= '0;
							ring_q  <= next_slot(ring_q);
							seen_q  <= seen_q + 1'b1;
							state_q <= ST_ACK;
						end else begin
							state_q <= ST_L1;
						end
					end
				end
				ST_L1: state_q <= ST_L2;
				ST_L2: state_q <= ST_L3;
				ST_L3: state_q <= ST_L4;
				ST_L4: state_q <= ST_L5;
				ST_L5: state_q <= ST_T0;
				ST_T0: state_q <= ST_T1;
				ST_T1: state_q <= ST_T2;
				ST_T2: state_q <= ST_T3;
				ST_T3: state_q <= ST_T4;
				ST_T4: state_q <= ST_T5;
				ST_T5: state_q <= ST_T6;
				ST_T6: begin
					trend_q <= sat_level(acc_rnd);
					level_q <= nl_q;
					ring_q  <= next_slot(ring_q);
					if (seen_q < SEEN_W'(SEASON_LEN + 1)) begin
						seen_q <= seen_q + 1'b1;
					end
					state_q <= (due_q && nl_pos) ? ST_D0 : ST_ACK;
				end
				ST_D0: state_q <= ST_D1;
				ST_D1: begin
					if (div_done) begin
						state_q <= ST_Q1;
					end
				end
				ST_Q1: state_q <= ST_Q2;
				ST_Q2: state_q <= ST_Q3;
				ST_Q3: state_q <= ST_Q4;
				ST_Q4: begin
					season_q[slot_q] <= sat_factor(acc_rnd);
					state_q          <= ST_ACK;
				end
				ST_ACK: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_F0: state_q <= ST_F1;
				ST_F1: state_q <= ST_F2;
				ST_F2: state_q <= ST_F3;
				ST_F3: state_q <= ST_F4;
				ST_F4: begin
					if (out_free) begin
						state_q <= t_last ? ST_IDLE : ST_F0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					sale_q  <= sale_count;
					slot_q  <= ring_q;
					due_q   <= (seen_q >= SEEN_W'(SEASON_LEN));
					fault_q <= 1'b0;
					x_q     <= DIFF_W'(level_q) + DIFF_W'(trend_q);
					n_q     <= n_in;
					t_q     <= HOR_W'(1);
					ft_q    <= FT_W'(level_q) + FT_W'(trend_q);
				end
			end
			ST_L5: nl_q <= sat_level(acc_rnd);
			ST_T0: x_q  <= DIFF_W'(nl_q) - DIFF_W'(level_q);
			ST_T6: fault_q <= due_q && !nl_pos;
			ST_ACK: begin
				if (out_free) begin
					forecast_q  <= '0;
					step_q      <= '0;
					last_q      <= 1'b1;
					fault_out_q <= fault_q;
				end
			end
			ST_F0: begin
				x_q   <= DIFF_W'(sat_level(ACC_W'(ft_q)));
				fac_q <= season_rd;
			end
			ST_F4: begin
				if (out_free) begin
					forecast_q  <= sat_out(acc_trunc);
					step_q      <= t_q;
					last_q      <= t_last;
					fault_out_q <= 1'b0;
					t_q         <= t_q + 1'b1;
					slot_q      <= next_slot(slot_q);
					ft_q        <= ft_q + FT_W'(trend_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign forecast    = forecast_q;
	assign step_ahead  = step_q;
	assign last        = last_q;
	assign level_fault = fault_out_q;

	a_div_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_D0) |-> (!nl_q[LEVEL_W-1] && (nl_q != '0)))
		else $error("divider started with non-positive level");

	a_ring_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ring_q < SLOT_W'(SEASON_LEN)) && (slot_q < SLOT_W'(SEASON_LEN) || state_q == ST_IDLE))
		else $error("ring slot out of range");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_F4) |-> ((t_q != '0) && (t_q <= n_q) && (n_q <= HOR_W'(MAX_STEPS))))
		else $error("forecast step out of range");

	a_fault_on_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && level_fault) |-> ((step_ahead == '0) && last))
		else $error("level fault on a forecast beat");

	a_div_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_D1 && div_done) |=> (state_q == ST_Q1 && !div_done))
		else $error("divider done not consumed");

endmodule

`default_nettype wire
